/* src/assert_macros.svh */
// Assertion macros used by the top level of the term enumerator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define SPTE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define SPTE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/spte_pkg.sv */
// Shared constants, types and helper functions of the term enumerator.
`default_nettype none

package spte_pkg;

    localparam int MAX_RANK   = 8;
    localparam int INDEX_BITS = 8;

    localparam int NUM_FIELDS = 8;
    localparam int FIELD_W    = 8;
    localparam int COEFF_W    = 32;
    localparam int RANK_W     = $clog2(MAX_RANK + 1);
    localparam int POS_W      = $clog2(MAX_RANK);
    localparam int FACT_W     = 16;
    localparam int DIV_STEPS  = COEFF_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0]  CFG_RANK = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_ANTI = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RANK_RESET = 4'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_NEXT = 1'b1;

    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [RANK_W-1:0]     rank_t;
    typedef logic [INDEX_BITS-1:0] idx_t;
    typedef logic [FACT_W-1:0]     fact_t;

    // controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic load;
        logic find;
        logic perm;
        logic emit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic in_action;
        logic exhausted;
        logic div_done;
        logic out_free;
    } status_t;

    // rank register value -> active rank, 0 taken as 1, clipped at MAX_RANK
    function automatic rank_t clamp_rank(input logic [CFG_DATA_W-1:0] v);
        rank_t r;
        if (v == '0)
        begin
            r = rank_t'(1);
        end
        else if (32'(v) > MAX_RANK)
        begin
            r = rank_t'(MAX_RANK);
        end
        else
        begin
            r = rank_t'(v);
        end
        return r;
    endfunction

    // rank factorial, rank already clamped
    function automatic fact_t rank_fact(input rank_t r);
        fact_t f;
        case (r)
            rank_t'(0): f = 16'd1;
            rank_t'(1): f = 16'd1;
            rank_t'(2): f = 16'd2;
            rank_t'(3): f = 16'd6;
            rank_t'(4): f = 16'd24;
            rank_t'(5): f = 16'd120;
            rank_t'(6): f = 16'd720;
            rank_t'(7): f = 16'd5040;
            default:    f = 16'd40320;
        endcase
        return f;
    endfunction

    function automatic idx_t from_field(input logic [FIELD_W-1:0] v);
        idx_t r;
        r = '0;
        for (int b = 0; b < INDEX_BITS && b < FIELD_W; b++)
        begin
            r[b] = v[b];
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input idx_t v);
        logic [FIELD_W-1:0] r;
        r = '0;
        for (int b = 0; b < INDEX_BITS && b < FIELD_W; b++)
        begin
            r[b] = v[b];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/spte_cfg_if.sv */
// Configuration write channel: register index and write data.
`default_nettype none

interface spte_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [spte_pkg::CFG_IDX_W-1:0]    index;
    logic [spte_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/spte_in_if.sv */
// Input item channel: action, element indices and coefficient.
`default_nettype none

interface spte_in_if;
    logic                               valid;
    logic                               ready;
    logic                               action;
    logic [spte_pkg::FIELD_W-1:0]       elt_index_0;
    logic [spte_pkg::FIELD_W-1:0]       elt_index_1;
    logic [spte_pkg::FIELD_W-1:0]       elt_index_2;
    logic [spte_pkg::FIELD_W-1:0]       elt_index_3;
    logic [spte_pkg::FIELD_W-1:0]       elt_index_4;
    logic [spte_pkg::FIELD_W-1:0]       elt_index_5;
    logic [spte_pkg::FIELD_W-1:0]       elt_index_6;
    logic [spte_pkg::FIELD_W-1:0]       elt_index_7;
    logic signed [spte_pkg::COEFF_W-1:0] coeff_in;

    modport source (output valid, output action, output elt_index_0, output elt_index_1,
                    output elt_index_2, output elt_index_3, output elt_index_4,
                    output elt_index_5, output elt_index_6, output elt_index_7,
                    output coeff_in, input ready);
    modport sink   (input valid, input action, input elt_index_0, input elt_index_1,
                    input elt_index_2, input elt_index_3, input elt_index_4,
                    input elt_index_5, input elt_index_6, input elt_index_7,
                    input coeff_in, output ready);
endinterface

`default_nettype wire

/* src/spte_out_if.sv */
// Result item channel: permuted indices, signed coefficient and last flag.
`default_nettype none

interface spte_out_if;
    logic                               valid;
    logic                               ready;
    logic [spte_pkg::FIELD_W-1:0]       out_index_0;
    logic [spte_pkg::FIELD_W-1:0]       out_index_1;
    logic [spte_pkg::FIELD_W-1:0]       out_index_2;
    logic [spte_pkg::FIELD_W-1:0]       out_index_3;
    logic [spte_pkg::FIELD_W-1:0]       out_index_4;
    logic [spte_pkg::FIELD_W-1:0]       out_index_5;
    logic [spte_pkg::FIELD_W-1:0]       out_index_6;
    logic [spte_pkg::FIELD_W-1:0]       out_index_7;
    logic signed [spte_pkg::COEFF_W-1:0] coeff_out;
    logic                               last;

    modport source (output valid, output out_index_0, output out_index_1,
                    output out_index_2, output out_index_3, output out_index_4,
                    output out_index_5, output out_index_6, output out_index_7,
                    output coeff_out, output last, input ready);
    modport sink   (input valid, input out_index_0, input out_index_1,
                    input out_index_2, input out_index_3, input out_index_4,
                    input out_index_5, input out_index_6, input out_index_7,
                    input coeff_out, input last, output ready);
endinterface

`default_nettype wire

/* src/spte_div.sv */
// Restoring divider, one quotient bit per cycle, truncates toward zero.
`default_nettype none

module spte_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [spte_pkg::COEFF_W-1:0] dividend,
    input  wire spte_pkg::fact_t                   divisor,
    output logic signed [spte_pkg::COEFF_W-1:0]    quotient,
    output logic                                   done
);

    logic                                busy_reg;
    logic [spte_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic                                neg_reg;
    logic [spte_pkg::COEFF_W-1:0]        num_reg;
    logic [spte_pkg::COEFF_W-1:0]        num_next;
    spte_pkg::fact_t                     rem_reg;
    spte_pkg::fact_t                     rem_next;
    spte_pkg::fact_t                     den_reg;
    logic [spte_pkg::FACT_W:0]           rem_sh;
    logic [spte_pkg::FACT_W:0]           rem_sub;
    logic                                fits;

    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[spte_pkg::COEFF_W-1]};
        fits     = (rem_sh >= {1'b0, den_reg});
        rem_sub  = rem_sh - {1'b0, den_reg};
        rem_next = fits ? rem_sub[spte_pkg::FACT_W-1:0] : rem_sh[spte_pkg::FACT_W-1:0];
        num_next = {num_reg[spte_pkg::COEFF_W-2:0], fits};
        done     = busy_reg && (cnt_reg == spte_pkg::DIV_CNT_W'(spte_pkg::DIV_STEPS - 1));
        quotient = neg_reg ? -$signed(num_next) : $signed(num_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[spte_pkg::COEFF_W-1];
            num_reg <= dividend[spte_pkg::COEFF_W-1] ? -dividend : dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

/* src/spte_dp.sv */
// Datapath: config registers, order and index lanes, divider, result register.
`default_nettype none

module spte_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    spte_cfg_if.sink           cfg_ch,
    spte_in_if.sink            in_ch,
    spte_out_if.source         out_ch,
    input  wire spte_pkg::cmd_t cmd,
    output spte_pkg::status_t  status
);

    localparam int M = spte_pkg::MAX_RANK;
    localparam int F = spte_pkg::NUM_FIELDS;
    localparam int W = spte_pkg::RANK_W + 1;

    logic [spte_pkg::CFG_DATA_W-1:0] cfg_rank_reg;
    logic                            cfg_anti_reg;
    spte_pkg::rank_t                 act_rank_reg;
    logic                            act_anti_reg;

    spte_pkg::pos_t  order_reg [M];
    spte_pkg::pos_t  order_next [M];
    spte_pkg::idx_t  val_reg [M];
    spte_pkg::idx_t  val_next [M];
    logic            parity_reg;
    logic            parity_next;
    logic            exhausted_reg;
    logic signed [spte_pkg::COEFF_W-1:0] scaled_reg;

    spte_pkg::pos_t  k_reg;
    spte_pkg::pos_t  j_reg;
    spte_pkg::pos_t  k_find;
    spte_pkg::pos_t  j_find;
    spte_pkg::pos_t  piv;

    logic [spte_pkg::FIELD_W-1:0] in_idx [F];
    logic [spte_pkg::FIELD_W-1:0] emit_idx [F];
    logic [spte_pkg::FIELD_W-1:0] out_idx_reg [F];
    logic signed [spte_pkg::COEFF_W-1:0] coeff_out_reg;
    logic            last_reg;
    logic            out_valid_reg;
    logic            last_now;

    spte_pkg::rank_t load_rank;
    logic signed [spte_pkg::COEFF_W-1:0] div_q;
    logic            div_done;

    assign in_idx[0] = in_ch.elt_index_0;
    assign in_idx[1] = in_ch.elt_index_1;
    assign in_idx[2] = in_ch.elt_index_2;
    assign in_idx[3] = in_ch.elt_index_3;
    assign in_idx[4] = in_ch.elt_index_4;
    assign in_idx[5] = in_ch.elt_index_5;
    assign in_idx[6] = in_ch.elt_index_6;
    assign in_idx[7] = in_ch.elt_index_7;

    assign load_rank = spte_pkg::clamp_rank(cfg_rank_reg);

    // ---- configuration port
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_rank_reg <= spte_pkg::RANK_RESET;
            cfg_anti_reg <= 1'b0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                spte_pkg::CFG_RANK: cfg_rank_reg <= cfg_ch.data;
                spte_pkg::CFG_ANTI: cfg_anti_reg <= cfg_ch.data[0];
                default:            ;
            endcase
        end
    end

    // ---- divider, started by a load
    spte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend (in_ch.coeff_in),
        .divisor  (spte_pkg::rank_fact(load_rank)),
        .quotient (div_q),
        .done     (div_done)
    );

    // ---- pivot and successor search
    always_comb
    begin
        k_find = '0;
        for (int p = 1; p < M; p++)
        begin
            if ((spte_pkg::rank_t'(p) < act_rank_reg) && (order_reg[p-1] < order_reg[p]))
            begin
                k_find = spte_pkg::pos_t'(p);
            end
        end
        piv = order_reg[k_find - 1'b1];
        j_find = '0;
        for (int q = 0; q < M; q++)
        begin
            if ((spte_pkg::pos_t'(q) >= k_find) && (spte_pkg::rank_t'(q) < act_rank_reg)
                && (order_reg[q] > piv))
            begin
                j_find = spte_pkg::pos_t'(q);
            end
        end
    end

    // ---- swap pivot with successor and reverse the suffix in one pass
    always_comb
    begin
        logic [W-1:0]   kw;
        logic [W-1:0]   nw;
        logic [W-1:0]   iw;
        logic [W-1:0]   rw;
        logic [W-1:0]   len;
        spte_pkg::pos_t km1;
        spte_pkg::pos_t src;
        kw  = W'(k_reg);
        nw  = W'(act_rank_reg);
        km1 = k_reg - 1'b1;
        for (int i = 0; i < M; i++)
        begin
            iw = W'(i);
            rw = kw + nw - iw - W'(1);
            if (spte_pkg::pos_t'(i) == km1)
            begin
                src = j_reg;
            end
            else if ((iw >= kw) && (iw < nw))
            begin
                src = (rw[spte_pkg::POS_W-1:0] == j_reg) ? km1 : rw[spte_pkg::POS_W-1:0];
            end
            else
            begin
                src = spte_pkg::pos_t'(i);
            end
            order_next[i] = order_reg[src];
            val_next[i]   = val_reg[src];
        end
        // swap flips parity; reversal adds floor(len/2) transpositions
        len         = nw - kw;
        parity_next = parity_reg ^ 1'b1 ^ len[1];
    end

    // ---- last: no ascent left in the active prefix
    always_comb
    begin
        logic succ;
        succ = 1'b0;
        for (int p = 0; p + 1 < M; p++)
        begin
            if ((spte_pkg::rank_t'(p + 1) < act_rank_reg) && (order_reg[p] < order_reg[p+1]))
            begin
                succ = 1'b1;
            end
        end
        last_now = !succ;
    end

    for (genvar g = 0; g < F; g++)
    begin : g_emit
        if (g < M)
        begin : g_used
            assign emit_idx[g] = (spte_pkg::rank_t'(g) < act_rank_reg)
                               ? spte_pkg::to_field(val_reg[g]) : '0;
        end
        else
        begin : g_unused
            assign emit_idx[g] = '0;
        end
    end

    // ---- enumeration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < M; i++)
            begin
                order_reg[i] <= spte_pkg::pos_t'(i);
            end
            act_rank_reg  <= spte_pkg::rank_t'(1);
            act_anti_reg  <= 1'b0;
            parity_reg    <= 1'b0;
            exhausted_reg <= 1'b1;
            scaled_reg    <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                for (int i = 0; i < M; i++)
                begin
                    order_reg[i] <= spte_pkg::pos_t'(i);
                end
                act_rank_reg  <= load_rank;
                act_anti_reg  <= cfg_anti_reg;
                parity_reg    <= 1'b0;
                exhausted_reg <= 1'b0;
            end
            else if (cmd.perm)
            begin
                order_reg  <= order_next;
                parity_reg <= parity_next;
            end
            if (cmd.emit)
            begin
                exhausted_reg <= last_now;
            end
            if (div_done)
            begin
                scaled_reg <= div_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < M; i++)
            begin
                val_reg[i] <= spte_pkg::from_field(in_idx[i]);
            end
        end
        else if (cmd.perm)
        begin
            val_reg <= val_next;
        end
        if (cmd.find)
        begin
            k_reg <= k_find;
            j_reg <= j_find;
        end
    end

    // ---- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_idx_reg   <= emit_idx;
            coeff_out_reg <= (act_anti_reg && parity_reg) ? -scaled_reg : scaled_reg;
            last_reg      <= last_now;
        end
    end

    assign in_ch.ready        = cmd.in_ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_index_0 = out_idx_reg[0];
    assign out_ch.out_index_1 = out_idx_reg[1];
    assign out_ch.out_index_2 = out_idx_reg[2];
    assign out_ch.out_index_3 = out_idx_reg[3];
    assign out_ch.out_index_4 = out_idx_reg[4];
    assign out_ch.out_index_5 = out_idx_reg[5];
    assign out_ch.out_index_6 = out_idx_reg[6];
    assign out_ch.out_index_7 = out_idx_reg[7];
    assign out_ch.coeff_out   = coeff_out_reg;
    assign out_ch.last        = last_reg;

    assign status.in_valid  = in_ch.valid;
    assign status.in_action = in_ch.action;
    assign status.exhausted = exhausted_reg;
    assign status.div_done  = div_done;
    assign status.out_free  = !out_valid_reg || out_ch.ready;

endmodule

`default_nettype wire

/* src/spte_ctrl.sv */
// Controller: sequences load/divide and next/permute, then the result write.
`default_nettype none

module spte_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire spte_pkg::status_t status,
    output spte_pkg::cmd_t        cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PERM,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    if (status.in_action == spte_pkg::ACT_LOAD)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_DIV;
                    end
                    else if (!status.exhausted)
                    begin
                        cmd.find   = 1'b1;
                        state_next = S_PERM;
                    end
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_PERM:
            begin
                cmd.perm   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* src/signed_permutation_term_enumerator_top.sv */
// Top level of the signed permutation term enumerator.
//
//  channel  dir  handshake     payload
//  cfg_ch   in   valid/ready   index (0 rank, 1 antisymmetric), data[3:0]
//  in_ch    in   valid/ready   action, elt_index_0..7, coeff_in (Q16.16)
//  out_ch   out  valid/ready   out_index_0..7, coeff_out (Q16.16), last
//
// Load item: accept starts the 32-step serial divider (coeff / rank!); the
//   quotient is written to the result register once the divider is done.
// Next item: accept + pivot search, swap/reverse pass, result write, in that order.
// Next item while exhausted: taken, no result.
// A finished result waits in the output register; a new item is taken meanwhile
//   and only its own result write stalls until the register frees.
// Reset: identity order, nothing loaded, rank register 2, antisymmetric 0.
`default_nettype none
`include "assert_macros.svh"

module signed_permutation_term_enumerator_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    spte_cfg_if.sink   cfg_ch,
    spte_in_if.sink    in_ch,
    spte_out_if.source out_ch
);

    spte_pkg::cmd_t    cmd;
    spte_pkg::status_t status;
    logic [3:0]        cmd_vec;

    // controller only talks to the datapath through cmd/status
    spte_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // datapath owns all channel payloads and the enumeration state
    spte_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .status (status)
    );

    assign cmd_vec = {cmd.load, cmd.find, cmd.perm, cmd.emit};

    // at most one datapath operation per cycle
    `SPTE_ASSERT(a_cmd_onehot, clk, rst_n, $onehot0(cmd_vec), "datapath commands overlap")

    // a result write never overwrites an untaken result
    `SPTE_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit, status.out_free,
        "result written while output register full")

    // an accepted load closes the input as the divider starts
    `SPTE_ASSERT_NEXT(a_load_busy, clk, rst_n,
        in_ch.valid && in_ch.ready && (in_ch.action == spte_pkg::ACT_LOAD),
        !in_ch.ready, "input open during divide")

endmodule

`default_nettype wire

/* test/signed_permutation_term_enumerator_top_tb.sv */
`timescale 1ns / 1ps
// Testbench of the term enumerator: directed and random items checked against a local predictor.
module signed_permutation_term_enumerator_top_tb;

    // One input item as the block sees it; elt[i] is elt_index_i.
    typedef struct packed {
        logic            action;
        logic [7:0][7:0] elt;
        logic [31:0]     coeff;
    } term_req_t;

    // One permuted term as the block emits it; idx[i] is out_index_i.
    typedef struct packed {
        logic [7:0][7:0] idx;
        logic [31:0]     coeff;
        logic            last;
    } perm_term_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Driven state of the three channels, known from time zero.
    term_req_t                       drv_req = '0;
    logic                            drv_valid = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [spte_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [spte_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            sink_ready = 1'b0;

    spte_cfg_if cfg_ch();
    spte_in_if  in_ch();
    spte_out_if out_ch();

    assign cfg_ch.valid      = cfg_valid;
    assign cfg_ch.index      = cfg_index;
    assign cfg_ch.data       = cfg_data;
    assign in_ch.valid       = drv_valid;
    assign in_ch.action      = drv_req.action;
    assign in_ch.elt_index_0 = drv_req.elt[0];
    assign in_ch.elt_index_1 = drv_req.elt[1];
    assign in_ch.elt_index_2 = drv_req.elt[2];
    assign in_ch.elt_index_3 = drv_req.elt[3];
    assign in_ch.elt_index_4 = drv_req.elt[4];
    assign in_ch.elt_index_5 = drv_req.elt[5];
    assign in_ch.elt_index_6 = drv_req.elt[6];
    assign in_ch.elt_index_7 = drv_req.elt[7];
    assign in_ch.coeff_in    = drv_req.coeff;
    assign out_ch.ready      = sink_ready;

    signed_permutation_term_enumerator_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    term_req_t  req_pending[$];   // items not yet offered to the block
    perm_term_t terms_due[$];     // predicted terms, oldest first

    // Predictor state: position order, loaded indices, scaled coefficient.
    logic [2:0]  pos_order [8];
    logic [7:0]  held_idx [8];
    logic [31:0] held_coeff;
    logic        odd_perm;
    logic        walk_done;
    int          live_rank;
    logic        live_anti;
    // Register mirror; only a load picks these up.
    logic [3:0]  reg_rank;
    logic        reg_anti;

    int         mismatches = 0;
    int         items_taken = 0;
    int         results_seen = 0;
    int         terms_predicted = 0;
    int         full_walks = 0;
    logic [8:0] ranks_loaded = '0;

    int in_gap, in_calm, out_stall, out_calm;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones; a calm
    // stretch forces zero gaps for a while.
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm = $urandom_range(20, 80);
        end
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (roll < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Rank code as written -> rank in use: zero means one, above 8 means 8.
    function automatic int eff_rank(input logic [3:0] code);
        if (code == 4'd0)
        begin
            return 1;
        end
        if (code > spte_pkg::MAX_RANK)
        begin
            return spte_pkg::MAX_RANK;
        end
        return int'(code);
    endfunction

    function automatic longint perm_count(input int r);
        longint f;
        f = 1;
        for (int i = 2; i <= r; i++)
        begin
            f = f * i;
        end
        return f;
    endfunction

    // True while some adjacent pair within the rank is still ascending.
    function automatic logic more_orders_left();
        for (int i = 0; i + 1 < live_rank; i++)
        begin
            if (pos_order[i] < pos_order[i + 1])
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Lexicographic successor: pivot, swap with successor, reverse suffix.
    // The swap flips parity; reversing len elements does len/2 more swaps.
    function automatic void step_order();
        int         k;
        int         j;
        int         lo;
        int         hi;
        logic [2:0] t;
        k = live_rank - 1;
        while (k > 0 && pos_order[k - 1] >= pos_order[k])
        begin
            k--;
        end
        if (k == 0)
        begin
            return;
        end
        j = live_rank - 1;
        while (j > k && pos_order[j] <= pos_order[k - 1])
        begin
            j--;
        end
        t = pos_order[k - 1];
        pos_order[k - 1] = pos_order[j];
        pos_order[j] = t;
        odd_perm = ~odd_perm;
        if ((((live_rank - k) / 2) % 2) == 1)
        begin
            odd_perm = ~odd_perm;
        end
        lo = k;
        hi = live_rank - 1;
        while (lo < hi)
        begin
            t = pos_order[lo];
            pos_order[lo] = pos_order[hi];
            pos_order[hi] = t;
            lo++;
            hi--;
        end
    endfunction

    // Positions at or past the rank read zero.
    function automatic perm_term_t emit_term();
        perm_term_t t;
        t = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < live_rank)
            begin
                t.idx[i] = held_idx[pos_order[i]];
            end
        end
        t.coeff = (live_anti && odd_perm) ? -held_coeff : held_coeff;
        t.last = !more_orders_left();
        if (t.last)
        begin
            walk_done = 1'b1;
        end
        return t;
    endfunction

    task automatic predict_term(input term_req_t r);
        longint c;
        if (r.action == spte_pkg::ACT_LOAD)
        begin
            live_rank = eff_rank(reg_rank);
            live_anti = reg_anti;
            for (int i = 0; i < 8; i++)
            begin
                held_idx[i] = r.elt[i];
                pos_order[i] = 3'(i);
            end
            c = $signed(r.coeff);
            held_coeff = 32'(c / perm_count(live_rank));   // truncates toward zero
            odd_perm = 1'b0;
            walk_done = 1'b0;
            ranks_loaded[live_rank] = 1'b1;
            terms_due.push_back(emit_term());
            terms_predicted++;
        end
        else if (!walk_done)
        begin
            step_order();
            terms_due.push_back(emit_term());
            terms_predicted++;
        end
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_term(input perm_term_t got);
        perm_term_t want;
        if (terms_due.size() == 0)
        begin
            flag_mismatch("result with nothing pending", got.coeff, 0);
            return;
        end
        want = terms_due.pop_front();
        for (int i = 0; i < 8; i++)
        begin
            if (got.idx[i] !== want.idx[i])
            begin
                flag_mismatch($sformatf("out_index_%0d", i), got.idx[i], want.idx[i]);
            end
        end
        if (got.coeff !== want.coeff)
        begin
            flag_mismatch("coeff_out", got.coeff, want.coeff);
        end
        if (got.last !== want.last)
        begin
            flag_mismatch("last", got.last, want.last);
        end
    endtask

    function automatic term_req_t mk_req(input logic act, input logic [63:0] elts,
                                         input logic [31:0] coeff);
        term_req_t r;
        r.action = act;
        r.elt = elts;
        r.coeff = coeff;
        return r;
    endfunction

    function automatic logic [31:0] pick_coeff();
        logic [31:0] small_val;
        small_val = $urandom_range(0, 300);
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return small_val;
            3:       return -small_val;
            default: return $urandom();
        endcase
    endfunction

    function automatic term_req_t make_req(input logic act);
        return mk_req(act, {$urandom(), $urandom()}, pick_coeff());
    endfunction

    // Random rank code: mostly small ranks, some large, some out of range.
    function automatic logic [3:0] pick_rank_code();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            return 4'd0;
        end
        if (roll < 18)
        begin
            return 4'($urandom_range(9, 15));
        end
        if (roll < 30)
        begin
            return 4'($urandom_range(6, 8));
        end
        return 4'($urandom_range(1, 5));
    endfunction

    task automatic write_reg(input logic [spte_pkg::CFG_IDX_W-1:0] idx,
                             input logic [spte_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ch.ready);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every item went in and every term came out, then let an
    // ignored next item finish before touching the registers.
    task automatic settle();
        while (req_pending.size() != 0 || drv_valid || terms_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (40) @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Input driver: offers queued items with random gaps
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            in_gap = 0;
            in_calm = 0;
        end
        else if (!drv_valid || in_ch.ready)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                drv_valid <= 1'b0;
            end
            else if (req_pending.size() != 0)
            begin
                drv_req <= req_pending.pop_front();
                drv_valid <= 1'b1;
                in_gap = pick_gap(in_calm);
            end
            else
            begin
                drv_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result side back-pressure
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
            out_stall = 0;
            out_calm = 0;
        end
        else if (out_stall > 0)
        begin
            out_stall--;
            sink_ready <= 1'b0;
        end
        else
        begin
            sink_ready <= 1'b1;
            if ($urandom_range(0, 99) < 30)
            begin
                out_stall = pick_gap(out_calm);
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: mirrors register writes, predicts on every accepted item,
    // checks every accepted result against the oldest prediction.
    // ---------------------------------------------------------------
    perm_term_t seen_term;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                pos_order[i] = 3'(i);
                held_idx[i] = '0;
            end
            held_coeff = '0;
            odd_perm = 1'b0;
            walk_done = 1'b1;       // nothing loaded yet
            live_rank = 1;
            live_anti = 1'b0;
            reg_rank = spte_pkg::RANK_RESET;
            reg_anti = 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == spte_pkg::CFG_RANK)
                begin
                    reg_rank = cfg_ch.data;
                end
                else
                begin
                    reg_anti = cfg_ch.data[0];
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                seen_term.idx[0] = out_ch.out_index_0;
                seen_term.idx[1] = out_ch.out_index_1;
                seen_term.idx[2] = out_ch.out_index_2;
                seen_term.idx[3] = out_ch.out_index_3;
                seen_term.idx[4] = out_ch.out_index_4;
                seen_term.idx[5] = out_ch.out_index_5;
                seen_term.idx[6] = out_ch.out_index_6;
                seen_term.idx[7] = out_ch.out_index_7;
                seen_term.coeff = out_ch.coeff_out;
                seen_term.last = out_ch.last;
                check_term(seen_term);
                results_seen++;
                if (seen_term.last)
                begin
                    full_walks++;
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                predict_term(drv_req);
                items_taken++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin : stim
        logic [3:0] rank_code;
        int         eff;
        longint     total;
        int         steps;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings (rank 2, plain sign). A next before any load is
        // dropped; a rank-2 walk ends after one step, then nothing.
        req_pending.push_back(mk_req(spte_pkg::ACT_NEXT, 64'hFFFF_FFFF_FFFF_FFFF,
                                     32'hFFFF_FFFF));
        req_pending.push_back(mk_req(spte_pkg::ACT_LOAD, 64'hFF00_A55A_0180_7EFF,
                                     32'h7FFF_FFFF));
        req_pending.push_back(mk_req(spte_pkg::ACT_NEXT, 64'h0, 32'h0));
        req_pending.push_back(mk_req(spte_pkg::ACT_NEXT, 64'h0, 32'h0));
        settle();

        // Rank code zero acts as rank one: the load term is already the last.
        write_reg(spte_pkg::CFG_RANK, 4'd0);
        write_reg(spte_pkg::CFG_ANTI, 4'b1111);
        req_pending.push_back(mk_req(spte_pkg::ACT_LOAD, 64'hFFFF_FFFF_FFFF_FFFF,
                                     32'h8000_0000));
        req_pending.push_back(mk_req(spte_pkg::ACT_NEXT, 64'h0, 32'h0));
        settle();

        // Rank code above the maximum clips to eight; most negative coefficient.
        write_reg(spte_pkg::CFG_RANK, 4'd15);
        write_reg(spte_pkg::CFG_ANTI, 4'b0001);
        req_pending.push_back(mk_req(spte_pkg::ACT_LOAD, 64'h0706_0504_0302_0100,
                                     32'h8000_0000));
        repeat (3) req_pending.push_back(mk_req(spte_pkg::ACT_NEXT, 64'h0, 32'h0));
        settle();

        // Full rank-3 walk with parity sign, plus one dropped next at the end.
        write_reg(spte_pkg::CFG_RANK, 4'd3);
        write_reg(spte_pkg::CFG_ANTI, 4'b1001);
        req_pending.push_back(mk_req(spte_pkg::ACT_LOAD, 64'h0000_0000_0030_2010,
                                     32'hFFF0_0001));
        repeat (6) req_pending.push_back(mk_req(spte_pkg::ACT_NEXT, 64'h0, 32'h0));
        settle();

        // Rank 4, plain sign; then registers change mid-walk and must not
        // affect the walk until the next load.
        write_reg(spte_pkg::CFG_RANK, 4'd4);
        write_reg(spte_pkg::CFG_ANTI, 4'b1110);
        req_pending.push_back(mk_req(spte_pkg::ACT_LOAD, 64'h8877_6655_4433_2211,
                                     32'h0001_0000));
        repeat (2) req_pending.push_back(mk_req(spte_pkg::ACT_NEXT, 64'h0, 32'h0));
        settle();
        write_reg(spte_pkg::CFG_RANK, 4'd8);
        write_reg(spte_pkg::CFG_ANTI, 4'b0001);
        repeat (3) req_pending.push_back(mk_req(spte_pkg::ACT_NEXT, 64'h0, 32'h0));
        req_pending.push_back(make_req(spte_pkg::ACT_LOAD));
        req_pending.push_back(make_req(spte_pkg::ACT_NEXT));
        settle();

        // Random phases: new settings, then loads each followed by a run of
        // next items, often to the end of the walk for small ranks, with a
        // little noise mixed in.
        while (items_taken < 1300)
        begin
            rank_code = pick_rank_code();
            write_reg(spte_pkg::CFG_RANK, rank_code);
            write_reg(spte_pkg::CFG_ANTI, 4'($urandom_range(0, 15)));
            eff = eff_rank(rank_code);
            total = perm_count(eff);
            repeat ($urandom_range(1, 3))
            begin
                req_pending.push_back(make_req(spte_pkg::ACT_LOAD));
                if (eff <= 5 && $urandom_range(0, 1) == 1)
                begin
                    steps = int'(total) - 1 + $urandom_range(0, 2);
                end
                else
                begin
                    steps = $urandom_range(0, (total < 24) ? int'(total) + 1 : 24);
                end
                repeat (steps) req_pending.push_back(make_req(spte_pkg::ACT_NEXT));
                if ($urandom_range(0, 99) < 15)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        req_pending.push_back(make_req(1'($urandom_range(0, 1))));
                    end
                end
            end
            settle();
        end

        settle();
        if (terms_due.size() != 0)
        begin
            flag_mismatch("terms never delivered", terms_due.size(), 0);
        end
        $display("%0d items accepted, %0d terms predicted, %0d checked, %0d walks ended on last",
                 items_taken, terms_predicted, results_seen, full_walks);
        $display("ranks loaded (bit per rank): %b, mismatches: %0d", ranks_loaded, mismatches);
        if (mismatches == 0)
        begin
            $display("signed_permutation_term_enumerator_top regression: pass");
        end
        else
        begin
            $display("signed_permutation_term_enumerator_top regression: fail");
        end
        $finish;
    end

    // Hang guard, far above the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("signed_permutation_term_enumerator_top regression: fail");
        $finish;
    end

endmodule
